/* rtl/lpu_pkg.sv */
`default_nettype none

package lpu_pkg;

  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned DataW          = 32;
  localparam int unsigned PixelW         = 16;
  localparam int unsigned PairW          = 7;
  localparam int unsigned CfgIndexW      = 2;
  localparam int unsigned CfgDataW       = 3;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] RegPixelMode    = 2'd0;
  localparam logic [CfgIndexW-1:0] RegByteOrderBig = 2'd1;
  localparam logic [CfgIndexW-1:0] RegPixOrderBig  = 2'd2;

  // pixel mode codes
  localparam logic [2:0] ModePal1  = 3'd0;
  localparam logic [2:0] ModePal2  = 3'd1;
  localparam logic [2:0] ModePal4  = 3'd2;
  localparam logic [2:0] ModePal8  = 3'd3;
  localparam logic [2:0] Mode16Bpp = 3'd4;
  localparam logic [2:0] Mode24Bpp = 3'd5;
  localparam logic [2:0] ModeRawA  = 3'd6;
  localparam logic [2:0] ModeRawB  = 3'd7;

  // command codes
  localparam logic CmdUnpack = 1'b0;
  localparam logic CmdPalWr  = 1'b1;

  // 1555 to 565 widening, wraps at 16 bits
  function automatic logic [PixelW-1:0] widen1555(input logic [PixelW-1:0] c);
    widen1555 = c + (c & 16'hFFE0) + ((c >> 10) & 16'h0020);
  endfunction

  // 888 packed down to 565
  function automatic logic [PixelW-1:0] pack888(input logic [DataW-1:0] w);
    pack888 = {w[23:19], w[15:10], w[7:3]};
  endfunction

endpackage

`default_nettype wire

/* rtl/lcd_pixel_unpack_rgb565_core.sv */
`default_nettype none

// channel  | valid       | stall        | payload
// ---------+-------------+--------------+---------------------------------------
// input    | in_valid_i  | in_stall_o   | command_i, data_word_i, palette_pair_i
// output   | out_valid_o | out_stall_i  | pixel_o, last_o
// config   | cfg_we_i    | (none)       | cfg_index_i, cfg_data_i
//
// one pixel per cycle while the output does not stall; a word gives 32 pixels at 1bpp,
// 4 at 8bpp, 2 at 16bpp, 1 at 24bpp; the single palette read port sets that rate
// from word accept the first pixel passes the sequencer, palette read and output
// registers in that order; a palette write gives no pixel
// reset clears the valid flags and config; palette contents are undefined until written
// output stall holds the output, earlier stages still fill bubbles; the next word is taken while the last pixel issues
module lcd_pixel_unpack_rgb565_core
  import lpu_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PaletteEntries
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  // configuration
  input  wire                    cfg_we_i,
  input  wire  [CfgIndexW-1:0]   cfg_index_i,
  input  wire  [CfgDataW-1:0]    cfg_data_i,
  // input words
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire                    command_i,
  input  wire  [DataW-1:0]       data_word_i,
  input  wire  [PairW-1:0]       palette_pair_i,
  // output pixels
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [PixelW-1:0]      pixel_o,
  output logic                   last_o
);

  localparam int unsigned IdxW  = $clog2(PALETTE_ENTRIES);
  localparam int unsigned RowW  = IdxW - 1;
  localparam int unsigned Rows  = PALETTE_ENTRIES / 2;
  localparam int unsigned CntW  = 5;

  // config registers
  logic [2:0] pixel_mode_q;
  logic       byte_order_big_q;
  logic       pixel_order_big_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_mode_q      <= ModePal1;
      byte_order_big_q  <= 1'b0;
      pixel_order_big_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPixelMode:    pixel_mode_q      <= cfg_data_i;
        RegByteOrderBig: byte_order_big_q  <= cfg_data_i[0];
        RegPixOrderBig:  pixel_order_big_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // palette memory, one row holds an even/odd entry pair
  logic [2*PixelW-1:0] pal_mem [Rows];
  logic [2*PixelW-1:0] rd_data_q;

  // pipe registers
  logic             s_valid_q;
  logic [DataW-1:0] s_word_q;
  logic [CntW-1:0]  s_idx_q;

  logic              m_valid_q;
  logic              m_pal_q;    // take pixel from palette read data
  logic              m_half_q;   // odd entry of the row
  logic              m_widen_q;  // apply 1555 to 565
  logic              m_last_q;
  logic [PixelW-1:0] m_pix_q;

  logic              o_valid_q;
  logic [PixelW-1:0] o_pix_q;
  logic              o_last_q;

  // pipe control
  logic o_ready, m_adv, s_issue, s_last, in_acc, pal_we;

  assign o_ready = !o_valid_q || !out_stall_i;
  assign m_adv   = !m_valid_q || o_ready;
  assign s_issue = s_valid_q && m_adv;

  // pixel count per word, minus one
  logic [CntW-1:0] last_idx;
  always_comb begin
    case (pixel_mode_q)
      ModePal1:  last_idx = 5'd31;
      ModePal2:  last_idx = 5'd15;
      ModePal4:  last_idx = 5'd7;
      ModePal8:  last_idx = 5'd3;
      Mode24Bpp: last_idx = 5'd0;
      default:   last_idx = 5'd1;
    endcase
  end

  assign s_last     = (s_idx_q == last_idx);
  assign in_stall_o = s_valid_q && !(s_issue && s_last);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pal_we     = in_acc && (command_i == CmdPalWr);

  // palettised index extraction for the current pixel
  logic            is_pal;
  logic [5:0]      span;
  logic [5:0]      pos;
  logic [4:0]      base_off;
  logic [4:0]      flip;
  logic [4:0]      bit_off;
  logic [DataW-1:0] shifted;
  logic [7:0]      idx_mask;
  logic [7:0]      idx8;
  logic [IdxW-1:0] pal_idx;

  assign is_pal   = (pixel_mode_q[2] == 1'b0);
  assign span     = ({1'b0, s_idx_q} + 6'd1) << pixel_mode_q[1:0];
  assign pos      = 6'd32 - span;
  assign base_off = byte_order_big_q ? 5'd0 : 5'd24;
  assign flip     = pixel_order_big_q ? 5'd0 : (5'd8 - (5'd1 << pixel_mode_q[1:0]));
  assign bit_off  = pos[4:0] ^ base_off ^ flip;
  assign shifted  = s_word_q >> bit_off;

  always_comb begin
    case (pixel_mode_q)
      ModePal1: idx_mask = 8'h01;
      ModePal2: idx_mask = 8'h03;
      ModePal4: idx_mask = 8'h0F;
      default:  idx_mask = 8'hFF;
    endcase
  end

  assign idx8    = shifted[7:0] & idx_mask;
  assign pal_idx = idx8[IdxW-1:0];

  // direct modes: halves in byte order
  logic [PixelW-1:0] half_first, half_second, direct_pix;
  assign half_first  = byte_order_big_q ? s_word_q[31:16] : s_word_q[15:0];
  assign half_second = byte_order_big_q ? s_word_q[15:0]  : s_word_q[31:16];

  always_comb begin
    if (pixel_mode_q == Mode24Bpp) begin
      direct_pix = pack888(s_word_q);
    end else begin
      direct_pix = s_idx_q[0] ? half_second : half_first;
    end
  end

  // sequencer stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      s_idx_q   <= '0;
    end else if (in_acc && (command_i == CmdUnpack)) begin
      s_valid_q <= 1'b1;
      s_idx_q   <= '0;
    end else if (s_issue && s_last) begin
      s_valid_q <= 1'b0;
    end else if (s_issue) begin
      s_idx_q <= s_idx_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (command_i == CmdUnpack)) begin
      s_word_q <= data_word_i;
    end
  end

  // palette write and read; a read in the write cycle sees the old row
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[palette_pair_i[RowW-1:0]] <= data_word_i;
    end
    if (s_issue && is_pal) begin
      rd_data_q <= pal_mem[pal_idx[IdxW-1:1]];
    end
  end

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (m_adv) begin
      m_valid_q <= s_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_issue) begin
      m_pal_q   <= is_pal;
      m_half_q  <= pal_idx[0];
      m_widen_q <= is_pal || (pixel_mode_q == Mode16Bpp);
      m_last_q  <= s_last;
      m_pix_q   <= direct_pix;
    end
  end

  // output register
  logic [PixelW-1:0] m_raw, m_final;
  assign m_raw   = m_pal_q ? (m_half_q ? rd_data_q[31:16] : rd_data_q[15:0]) : m_pix_q;
  assign m_final = m_widen_q ? widen1555(m_raw) : m_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_ready && m_valid_q) begin
      o_pix_q  <= m_final;
      o_last_q <= m_last_q;
    end
  end

  assign out_valid_o = o_valid_q;
  assign pixel_o     = o_pix_q;
  assign last_o      = o_last_q;

endmodule

`default_nettype wire

/* test/pixel_stream_monitor.sv */
module pixel_stream_monitor
  import lpu_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [CfgIndexW-1:0] cfg_index_i,
  input  wire  [CfgDataW-1:0]  cfg_data_i,
  input  wire                  in_valid_i,
  input  wire                  in_stall_i,
  input  wire                  command_i,
  input  wire  [DataW-1:0]     data_word_i,
  input  wire  [PairW-1:0]     palette_pair_i,
  input  wire                  out_valid_i,
  input  wire                  out_stall_i,
  input  wire  [PixelW-1:0]    pixel_i,
  input  wire                  last_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              last;
  } pixel_exp_t;

  pixel_exp_t        pixel_fifo[$];
  logic [PixelW-1:0] palette_q [PaletteEntries];
  logic [2:0]        mode_q     = ModePal1;
  logic              byte_big_q = 1'b0;
  logic              pix_big_q  = 1'b0;
  int                fails      = 0;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
    foreach (palette_q[i]) palette_q[i] = '0;
  end

  // 1555 entry widened to 565
  function automatic logic [PixelW-1:0] to_rgb565(input logic [PixelW-1:0] c);
    return c + {c[15:5], 5'b0} + {10'b0, c[15], 5'b0};
  endfunction

  function automatic void unpack_word(input logic [DataW-1:0] w);
    int                bpp;
    int                base;
    logic [7:0]        idx;
    logic [PixelW-1:0] first;
    logic [PixelW-1:0] second;
    first  = byte_big_q ? w[31:16] : w[15:0];
    second = byte_big_q ? w[15:0] : w[31:16];
    if (mode_q <= ModePal8) begin
      bpp  = 1 << mode_q;
      base = byte_big_q ? 0 : 24;
      if (!pix_big_q) base = base ^ (8 - bpp);
      for (int p = 32 - bpp; p >= 0; p -= bpp) begin
        idx = 8'((w >> ((p ^ base) & 31)) & ((1 << bpp) - 1));
        pixel_fifo.push_back('{pixel: to_rgb565(palette_q[idx]), last: (p == 0)});
      end
    end else if (mode_q == Mode16Bpp) begin
      pixel_fifo.push_back('{pixel: to_rgb565(first), last: 1'b0});
      pixel_fifo.push_back('{pixel: to_rgb565(second), last: 1'b1});
    end else if (mode_q == Mode24Bpp) begin
      pixel_fifo.push_back('{pixel: {w[23:19], w[15:10], w[7:3]}, last: 1'b1});
    end else begin
      pixel_fifo.push_back('{pixel: first, last: 1'b0});
      pixel_fifo.push_back('{pixel: second, last: 1'b1});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_exp_t exp_px;
    if (!rst_ni) begin
      mode_q     = ModePal1;
      byte_big_q = 1'b0;
      pix_big_q  = 1'b0;
      pixel_fifo.delete();
    end else begin
      // outputs first: a pixel can never stem from a word taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (pixel_fifo.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected pixel %h last %b", $time, pixel_i, last_i);
        end else begin
          exp_px = pixel_fifo.pop_front();
          if (pixel_i !== exp_px.pixel || last_i !== exp_px.last) begin
            fails++;
            if (fails <= 10)
              $display("%0t: pixel mismatch, expected %h last %b, got %h last %b",
                       $time, exp_px.pixel, exp_px.last, pixel_i, last_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegPixelMode:    mode_q     = cfg_data_i[2:0];
          RegByteOrderBig: byte_big_q = cfg_data_i[0];
          RegPixOrderBig:  pix_big_q  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (command_i == CmdPalWr) begin
          palette_q[{palette_pair_i, 1'b0}] = data_word_i[15:0];
          palette_q[{palette_pair_i, 1'b1}] = data_word_i[31:16];
        end else begin
          unpack_word(data_word_i);
        end
      end
    end
    pending_o    <= pixel_fifo.size();
    fail_count_o <= fails;
  end

endmodule

/* test/testbench.sv */
module testbench;
  import lpu_pkg::*;

  // receiver stall patterns, switched per window
  typedef enum int unsigned {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_pat_e;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 cfg_we       = 1'b0;
  logic [CfgIndexW-1:0] cfg_index    = '0;
  logic [CfgDataW-1:0]  cfg_data     = '0;
  logic                 in_valid     = 1'b0;
  logic                 command      = CmdUnpack;
  logic [DataW-1:0]     data_word    = '0;
  logic [PairW-1:0]     palette_pair = '0;
  logic                 out_stall    = 1'b0;
  wire                  in_stall;
  wire                  out_valid;
  wire  [PixelW-1:0]    pixel;
  wire                  last;

  int pending;
  int fail_count;

  // stimulus-side view of the block: which palette entries hold data, current mode
  bit         pal_written [PaletteEntries];
  logic [2:0] cur_mode   = ModePal1;
  int         burst_left = 0;

  stall_pat_e  stall_pat = StallNone;
  int unsigned stall_cnt = 0;

  lcd_pixel_unpack_rgb565_core u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .data_word_i    (data_word),
    .palette_pair_i (palette_pair),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_o        (pixel),
    .last_o         (last)
  );

  // prediction and comparison live in the monitor, the top only drives and judges
  pixel_stream_monitor u_monitor (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .command_i      (command),
    .data_word_i    (data_word),
    .palette_pair_i (palette_pair),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_i        (pixel),
    .last_i         (last),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard limit, far above the slowest legal run
  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  // receiver stall: none, light, heavy or a fixed period, chosen per window
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 48 == 0) stall_pat <= stall_pat_e'($urandom_range(0, 3));
    case (stall_pat)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall <= ($urandom_range(0, 3) != 0);
      default:    out_stall <= ((stall_cnt % 5) < 2);
    endcase
  end

  // one word per call; a gap opens before a new burst, valid stays up inside one
  task automatic send_item(input logic cmd, input logic [DataW-1:0] w,
                           input logic [PairW-1:0] pair);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    data_word    <= w;
    palette_pair <= pair;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (cmd == CmdPalWr) begin
      pal_written[{pair, 1'b0}] = 1'b1;
      pal_written[{pair, 1'b1}] = 1'b1;
    end
  endtask

  // let every pending pixel drain, then wait for a trailing palette write
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // all three registers, back to back on an idle block
  task automatic apply_setting(input logic [2:0] mode, input logic byte_big,
                               input logic pix_big);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= RegPixelMode;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_index <= RegByteOrderBig;
    cfg_data  <= {2'b0, byte_big};
    @(posedge clk);
    cfg_index <= RegPixOrderBig;
    cfg_data  <= {2'b0, pix_big};
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode = mode;
  endtask

  // swap any index that points at an empty palette entry for one of entries 0..3
  function automatic logic [DataW-1:0] fit_palette(input logic [DataW-1:0] w);
    int               bpp;
    logic [DataW-1:0] mask;
    logic [DataW-1:0] idx;
    bpp  = 1 << cur_mode;
    mask = (32'd1 << bpp) - 1;
    for (int pos = 0; pos < 32; pos += bpp) begin
      idx = (w >> pos) & mask;
      if (!pal_written[idx]) begin
        w = w & ~(mask << pos);
        w = w | ((idx & 3) << pos);
      end
    end
    return w;
  endfunction

  task automatic random_item();
    logic [DataW-1:0] w;
    int               roll;
    roll = $urandom_range(0, 99);
    w    = $urandom;
    if (roll < 15) begin
      send_item(CmdPalWr, w, 7'($urandom_range(0, 127)));
    end else begin
      if (roll < 20) w = '0;
      else if (roll < 25) w = '1;
      if (cur_mode <= ModePal8) w = fit_palette(w);
      // pair field is ignored on unpack words, so it stays random
      send_item(CmdUnpack, w, 7'($urandom_range(0, 127)));
    end
  endtask

  initial begin
    int drain_cycles;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // palette: black/white, the 1555 extremes, top pair, one in the middle
    send_item(CmdPalWr, 32'hFFFF_0000, 7'd0);
    send_item(CmdPalWr, 32'h8000_7FFF, 7'd1);
    send_item(CmdPalWr, 32'h0420_FBDF, 7'd127);
    send_item(CmdPalWr, $urandom, 7'd64);

    // reset setting: 1bpp, little-endian bytes and pixels
    send_item(CmdUnpack, 32'hAAAA_5555, 7'd0);
    apply_setting(ModePal2, 1'b1, 1'b1);
    send_item(CmdUnpack, 32'h1B1B_E4E4, 7'd127);
    apply_setting(ModePal4, 1'b0, 1'b1);
    send_item(CmdUnpack, 32'h0123_3210, 7'd0);
    apply_setting(ModePal8, 1'b1, 1'b0);
    send_item(CmdUnpack, 32'hFF00_FE03, 7'd0);
    send_item(CmdUnpack, 32'h8180_0100, 7'd0);
    apply_setting(Mode16Bpp, 1'b1, 1'b0);
    send_item(CmdUnpack, 32'hFFFF_0000, 7'd0);
    send_item(CmdUnpack, 32'h8000_7FFF, 7'd0);
    apply_setting(Mode24Bpp, 1'b0, 1'b1);
    send_item(CmdUnpack, 32'hFFFF_FFFF, 7'd0);
    send_item(CmdUnpack, 32'h0000_0000, 7'd0);
    send_item(CmdUnpack, 32'h00F8_1C07, 7'd0);
    // palette write while in a direct color mode
    send_item(CmdPalWr, 32'h1234_5678, 7'd2);
    apply_setting(ModeRawA, 1'b1, 1'b1);
    send_item(CmdUnpack, 32'h1234_ABCD, 7'd0);
    apply_setting(ModeRawB, 1'b0, 1'b0);
    send_item(CmdUnpack, 32'hFFFF_0001, 7'd0);
    send_item(CmdUnpack, 32'h0001_FFFF, 7'd0);
    apply_setting(Mode16Bpp, 1'b0, 1'b1);
    send_item(CmdUnpack, 32'h0000_FFFF, 7'd0);
    apply_setting(ModePal1, 1'b1, 1'b0);
    send_item(CmdUnpack, 32'h8000_0001, 7'd0);

    // random phases, each under its own setting
    for (int ph = 0; ph < 10; ph++) begin
      apply_setting(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      repeat (20) random_item();
    end

    // wind down: wait for the pipe to empty, then watch for stray pixels
    in_valid     <= 1'b0;
    drain_cycles = 0;
    while (pending != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (pending != 0) begin
      $display("TB_ERROR");
    end else begin
      repeat (20) @(posedge clk);
      if (fail_count == 0 && pending == 0) begin
        $display("TB_OK");
      end else begin
        $display("TB_ERROR");
      end
    end
    $finish;
  end

endmodule
